// ===== src/cau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Operation codes, status codes and the control word of the pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_MUL = 2'd2;
    localparam logic [1:0] FUNC_DIV = 2'd3;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [1:0] func;
    } t_ctrl;

endpackage

// ===== src/cau_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit channels
// Operand channel and result channel with valid and ready.
// ----------------------------------------------------------------------------
interface cau_in_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic signed [W-1:0] a_re;
    logic signed [W-1:0] a_im;
    logic signed [W-1:0] b_re;
    logic signed [W-1:0] b_im;

    modport source(output valid, func, a_re, a_im, b_re, b_im, input ready);
    modport sink(input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] res_re;
    logic signed [W-1:0] res_im;
    logic [1:0]          status;

    modport source(output valid, res_re, res_im, status, input ready);
    modport sink(input valid, res_re, res_im, status, output ready);
endinterface

// ===== src/complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply or divide two signed fixed point complex numbers.
// ----------------------------------------------------------------------------
// Operands and the operation code arrive on i_in; one result per operand
// transfer leaves on o_out with res_re, res_im and a status code.
// The pipeline takes a new transfer in every cycle while o_out is not stalled.
// A result passes through these registers in order: operand register,
// products, sums, divider setup, one divider stage for each of the
// DATA_WIDTH + 1 quotient bits, and rounding with the output register.
// All four operations share this one path.
// When the receiver holds o_out.ready low with a result waiting, the whole
// pipeline holds and i_in.ready drops in the same cycle; nothing is lost.
// Reset clears every valid bit, so o_out.valid is low after reset.
// Division by zero gives zero with status 1; saturation gives status 2.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cau_in_if.sink     i_in,
    cau_out_if.source  o_out
);

    localparam int MW = 2 * DATA_WIDTH + 1;
    localparam int RW = 3 * DATA_WIDTH + FRAC_BITS + 2;

    logic                         en;
    cau_pkg::t_ctrl               f_ctrl, d_ctrl;
    logic [1:0]                   f_neg, d_neg;
    logic [1:0][MW-1:0]           f_mag, d_mag;
    logic [2*DATA_WIDTH-1:0]      f_den, d_den;
    logic [1:0]                   d_ovf;
    logic [1:0][RW-1:0]           d_rem;
    logic [1:0][DATA_WIDTH:0]     d_q;
    logic [DATA_WIDTH-1:0]        res_re, res_im;

    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    cau_front #(.W(DATA_WIDTH), .MW(MW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_func  (i_in.func),
        .i_a_re  (i_in.a_re),
        .i_a_im  (i_in.a_im),
        .i_b_re  (i_in.b_re),
        .i_b_im  (i_in.b_im),
        .o_ctrl  (f_ctrl),
        .o_neg   (f_neg),
        .o_mag   (f_mag),
        .o_den   (f_den)
    );

    cau_div #(.W(DATA_WIDTH), .F(FRAC_BITS), .MW(MW), .RW(RW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctrl  (f_ctrl),
        .i_neg   (f_neg),
        .i_mag   (f_mag),
        .i_den   (f_den),
        .o_ctrl  (d_ctrl),
        .o_neg   (d_neg),
        .o_mag   (d_mag),
        .o_den   (d_den),
        .o_ovf   (d_ovf),
        .o_rem   (d_rem),
        .o_q     (d_q)
    );

    cau_post #(.W(DATA_WIDTH), .F(FRAC_BITS), .MW(MW), .RW(RW)) u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctrl   (d_ctrl),
        .i_neg    (d_neg),
        .i_mag    (d_mag),
        .i_den    (d_den),
        .i_ovf    (d_ovf),
        .i_rem    (d_rem),
        .i_q      (d_q),
        .o_valid  (o_out.valid),
        .o_res_re (res_re),
        .o_res_im (res_im),
        .o_status (o_out.status)
    );

    assign o_out.res_re = res_re;
    assign o_out.res_im = res_im;

endmodule

// ===== src/cau_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Operand register, product stage and sum stage giving sign and magnitude.
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int W  = 16,
    parameter int MW = 2 * W + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [1:0]            i_func,
    input  logic signed [W-1:0]   i_a_re,
    input  logic signed [W-1:0]   i_a_im,
    input  logic signed [W-1:0]   i_b_re,
    input  logic signed [W-1:0]   i_b_im,
    output cau_pkg::t_ctrl        o_ctrl,
    output logic [1:0]            o_neg,
    output logic [1:0][MW-1:0]    o_mag,
    output logic [2*W-1:0]        o_den
);

    cau_pkg::t_ctrl        r_a_ctrl, r_b_ctrl, r_c_ctrl;
    logic signed [W-1:0]   r_ar, r_ai, r_br, r_bi;
    logic signed [2*W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bb, r_p_cc;
    logic signed [W:0]     r_s_re, r_s_im;
    logic signed [MW-1:0]  n_s [2];
    logic [1:0]            r_neg;
    logic [1:0][MW-1:0]    r_mag;
    logic [2*W-1:0]        r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctrl.valid <= 1'b0;
            r_b_ctrl.valid <= 1'b0;
            r_c_ctrl.valid <= 1'b0;
        end else if (i_en) begin
            r_a_ctrl <= '{valid: i_valid, func: i_func};
            r_b_ctrl <= r_a_ctrl;
            r_c_ctrl <= r_b_ctrl;
        end
    end

    always_comb begin
        case (r_b_ctrl.func)
            cau_pkg::FUNC_MUL: begin
                n_s[0] = MW'(r_p_rr) - MW'(r_p_ii);
                n_s[1] = MW'(r_p_ri) + MW'(r_p_ir);
            end
            cau_pkg::FUNC_DIV: begin
                n_s[0] = MW'(r_p_rr) + MW'(r_p_ii);
                n_s[1] = MW'(r_p_ir) - MW'(r_p_ri);
            end
            default: begin
                n_s[0] = MW'(r_s_re);
                n_s[1] = MW'(r_s_im);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ar   <= i_a_re;
            r_ai   <= i_a_im;
            r_br   <= i_b_re;
            r_bi   <= i_b_im;
            r_p_rr <= r_ar * r_br;
            r_p_ii <= r_ai * r_bi;
            r_p_ri <= r_ar * r_bi;
            r_p_ir <= r_ai * r_br;
            r_p_bb <= r_br * r_br;
            r_p_cc <= r_bi * r_bi;
            if (r_a_ctrl.func == cau_pkg::FUNC_SUB) begin
                r_s_re <= (W+1)'(r_ar) - (W+1)'(r_br);
                r_s_im <= (W+1)'(r_ai) - (W+1)'(r_bi);
            end else begin
                r_s_re <= (W+1)'(r_ar) + (W+1)'(r_br);
                r_s_im <= (W+1)'(r_ai) + (W+1)'(r_bi);
            end
            for (int l = 0; l < 2; l++) begin
                r_neg[l] <= n_s[l][MW-1];
                r_mag[l] <= n_s[l][MW-1] ? MW'(-n_s[l]) : MW'(n_s[l]);
            end
            r_den <= (2*W)'(r_p_bb) + (2*W)'(r_p_cc);
        end
    end

    assign o_ctrl = r_c_ctrl;
    assign o_neg  = r_neg;
    assign o_mag  = r_mag;
    assign o_den  = r_den;

endmodule

// ===== src/cau_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider
// Restoring divider, one quotient bit per stage, both parts side by side.
// ----------------------------------------------------------------------------
module cau_div #(
    parameter int W  = 16,
    parameter int F  = 8,
    parameter int MW = 2 * W + 1,
    parameter int RW = 3 * W + F + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  cau_pkg::t_ctrl        i_ctrl,
    input  logic [1:0]            i_neg,
    input  logic [1:0][MW-1:0]    i_mag,
    input  logic [2*W-1:0]        i_den,
    output cau_pkg::t_ctrl        o_ctrl,
    output logic [1:0]            o_neg,
    output logic [1:0][MW-1:0]    o_mag,
    output logic [2*W-1:0]        o_den,
    output logic [1:0]            o_ovf,
    output logic [1:0][RW-1:0]    o_rem,
    output logic [1:0][W:0]       o_q
);

    localparam int NS = W + 2;

    cau_pkg::t_ctrl     r_ctrl [NS];
    logic [1:0]         r_neg  [NS];
    logic [1:0][MW-1:0] r_mag  [NS];
    logic [2*W-1:0]     r_den  [NS];
    logic [1:0]         r_ovf  [NS];
    logic [1:0][RW-1:0] r_rem  [NS];
    logic [1:0][W:0]    r_q    [NS];
    logic [RW-1:0]      n_num  [2];
    logic [RW-1:0]      n_dmax;

    always_comb begin
        n_dmax = RW'(i_den) << (W + 1);
        for (int l = 0; l < 2; l++) begin
            n_num[l] = RW'(i_mag[l]) << F;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl[0].valid <= 1'b0;
        end else if (i_en) begin
            r_ctrl[0] <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= i_neg;
            r_mag[0] <= i_mag;
            r_den[0] <= i_den;
            for (int l = 0; l < 2; l++) begin
                r_ovf[0][l] <= n_num[l] >= n_dmax;
                r_rem[0][l] <= n_num[l];
                r_q[0][l]   <= '0;
            end
        end
    end

    for (genvar i = 1; i < NS; i++) begin : g_stage
        localparam int B = W - (i - 1);
        logic [RW-1:0]      dsh;
        logic [1:0]         ge;
        logic [1:0][RW-1:0] n_rem;

        always_comb begin
            dsh = RW'(r_den[i-1]) << B;
            for (int l = 0; l < 2; l++) begin
                ge[l]    = r_rem[i-1][l] >= dsh;
                n_rem[l] = ge[l] ? r_rem[i-1][l] - dsh : r_rem[i-1][l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctrl[i].valid <= 1'b0;
            end else if (i_en) begin
                r_ctrl[i] <= r_ctrl[i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[i] <= r_neg[i-1];
                r_mag[i] <= r_mag[i-1];
                r_den[i] <= r_den[i-1];
                r_ovf[i] <= r_ovf[i-1];
                r_rem[i] <= n_rem;
                for (int l = 0; l < 2; l++) begin
                    r_q[i][l] <= {r_q[i-1][l][W-1:0], ge[l]};
                end
            end
        end
    end

    assign o_ctrl = r_ctrl[NS-1];
    assign o_neg  = r_neg[NS-1];
    assign o_mag  = r_mag[NS-1];
    assign o_den  = r_den[NS-1];
    assign o_ovf  = r_ovf[NS-1];
    assign o_rem  = r_rem[NS-1];
    assign o_q    = r_q[NS-1];

endmodule

// ===== src/cau_post.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Rounding, saturation, status and the output register.
// ----------------------------------------------------------------------------
module cau_post #(
    parameter int W  = 16,
    parameter int F  = 8,
    parameter int MW = 2 * W + 1,
    parameter int RW = 3 * W + F + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  cau_pkg::t_ctrl        i_ctrl,
    input  logic [1:0]            i_neg,
    input  logic [1:0][MW-1:0]    i_mag,
    input  logic [2*W-1:0]        i_den,
    input  logic [1:0]            i_ovf,
    input  logic [1:0][RW-1:0]    i_rem,
    input  logic [1:0][W:0]       i_q,
    output logic                  o_valid,
    output logic [W-1:0]          o_res_re,
    output logic [W-1:0]          o_res_im,
    output logic [1:0]            o_status
);

    localparam logic [MW:0] HALF = (MW+1)'(2 ** F) >> 1;
    localparam logic [MW:0] LIM  = (MW+1)'(1) << (W - 1);

    logic [MW:0]         m [2];
    logic [1:0]          ng;
    logic [1:0]          rnd;
    logic                sat;
    logic [1:0][W-1:0]   n_res;
    logic [1:0]          n_status;
    logic                r_valid;
    logic [1:0][W-1:0]   r_res;
    logic [1:0]          r_status;

    always_comb begin
        sat = 1'b0;
        for (int l = 0; l < 2; l++) begin
            rnd[l] = {i_rem[l][RW-2:0], 1'b0} >= RW'(i_den);
            case (i_ctrl.func)
                cau_pkg::FUNC_MUL: m[l] = ((MW+1)'(i_mag[l]) + HALF) >> F;
                cau_pkg::FUNC_DIV: m[l] = i_ovf[l] ? '1 : (MW+1)'(i_q[l]) + (MW+1)'(rnd[l]);
                default:           m[l] = (MW+1)'(i_mag[l]);
            endcase
            ng[l] = i_neg[l] && (m[l] != '0);
            if (ng[l]) begin
                if (m[l] > LIM) begin
                    m[l] = LIM;
                    sat  = 1'b1;
                end
                n_res[l] = W'((~m[l]) + (MW+1)'(1));
            end else begin
                if (m[l] > LIM - (MW+1)'(1)) begin
                    m[l] = LIM - (MW+1)'(1);
                    sat  = 1'b1;
                end
                n_res[l] = W'(m[l]);
            end
        end
        n_status = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        if (i_ctrl.func == cau_pkg::FUNC_DIV && i_den == '0) begin
            n_res    = '0;
            n_status = cau_pkg::ST_DZ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res    <= n_res;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_res_re = r_res[0];
    assign o_res_im = r_res[1];
    assign o_status = r_status;

endmodule

// ===== src/cau_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit checker
// Port level assertions, attached to the top level by bind.
// ----------------------------------------------------------------------------
module cau_checker #(
    parameter int W = 16
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [W-1:0] i_res_re,
    input logic [W-1:0] i_res_im,
    input logic [1:0]   i_status
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid after reset.");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == cau_pkg::ST_DZ) |-> (i_res_re == '0 && i_res_im == '0))
        else $error("Division by zero with a nonzero result.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == cau_pkg::ST_OK || i_status == cau_pkg::ST_DZ
                         || i_status == cau_pkg::ST_SAT))
        else $error("Undefined status code.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("Input stalled with no result waiting.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_res_re) && $stable(i_res_im) && $stable(i_status)))
        else $error("Stalled result changed.");

endmodule

bind complex_arithmetic_unit cau_checker #(.W(DATA_WIDTH)) u_cau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_res_re    (o_out.res_re),
    .i_res_im    (o_out.res_im),
    .i_status    (o_out.status)
);

// ===== verif/complex_arithmetic_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit checker
// Watches the operand and result channels, predicts each result from the
// operands and compares it field by field with what the unit delivers.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_checker #(
    parameter int W    = 16,
    parameter int FRAC = 8
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    cau_in_if      i_in,
    cau_out_if     i_out,
    output int     o_errors,
    output int     o_pending
);

    typedef struct {
        logic signed [W-1:0] re;
        logic signed [W-1:0] im;
        logic [1:0]          status;
    } t_cplx_res;

    t_cplx_res expected_results[$];

    // Restores the sign of a magnitude and clamps it to the field range.
    function automatic logic signed [W-1:0] clamp_sm(input logic [127:0] mag, input bit neg,
                                                      inout bit sat);
        logic [127:0] lim;
        lim = 128'd1 << (W - 1);
        if (neg) begin
            if (mag > lim) begin
                mag = lim;
                sat = 1;
            end
            return W'(-mag);
        end
        if (mag > lim - 128'd1) begin
            mag = lim - 128'd1;
            sat = 1;
        end
        return W'(mag);
    endfunction

    function automatic logic signed [W-1:0] clamp_sum(input longint v, inout bit sat);
        return clamp_sm(128'(v < 0 ? -v : v), v < 0, sat);
    endfunction

    function automatic logic signed [W-1:0] scale_product(input longint s, inout bit sat);
        logic [127:0] mag;
        mag = 128'(s < 0 ? -s : s);
        if (FRAC > 0) mag = (mag + (128'd1 << (FRAC - 1))) >> FRAC;
        return clamp_sm(mag, s < 0 && mag != 0, sat);
    endfunction

    function automatic logic signed [W-1:0] scale_quotient(input longint s, input longint den,
                                                            inout bit sat);
        logic [127:0] num, dv, q, r;
        num = 128'(s < 0 ? -s : s);
        num = num << FRAC;
        dv = 128'(den);
        q = num / dv;
        r = num % dv;
        if ((r << 1) >= dv) q = q + 128'd1;
        return clamp_sm(q, s < 0 && q != 0, sat);
    endfunction

    function automatic t_cplx_res predict_result(input logic [1:0] func,
                                                 input longint ar, ai, br, bi);
        t_cplx_res r;
        bit sat;
        longint den;
        sat = 0;
        r.re = '0;
        r.im = '0;
        r.status = cau_pkg::ST_OK;
        case (func)
            cau_pkg::FUNC_ADD: begin
                r.re = clamp_sum(ar + br, sat);
                r.im = clamp_sum(ai + bi, sat);
            end
            cau_pkg::FUNC_SUB: begin
                r.re = clamp_sum(ar - br, sat);
                r.im = clamp_sum(ai - bi, sat);
            end
            cau_pkg::FUNC_MUL: begin
                r.re = scale_product(ar * br - ai * bi, sat);
                r.im = scale_product(ar * bi + ai * br, sat);
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.status = cau_pkg::ST_DZ;
                end else begin
                    r.re = scale_quotient(ar * br + ai * bi, den, sat);
                    r.im = scale_quotient(ai * br - ar * bi, den, sat);
                end
            end
        endcase
        if (r.status == cau_pkg::ST_OK && sat) r.status = cau_pkg::ST_SAT;
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_cplx_res e;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                expected_results.push_back(predict_result(i_in.func,
                    longint'(i_in.a_re), longint'(i_in.a_im),
                    longint'(i_in.b_re), longint'(i_in.b_im)));
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result re=%0d im=%0d status=%0d", $time,
                             i_out.res_re, i_out.res_im, i_out.status);
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (e.re !== i_out.res_re || e.im !== i_out.res_im
                        || e.status !== i_out.status) begin
                        $display("%0t: exp re=%0d im=%0d st=%0d, got re=%0d im=%0d st=%0d",
                                 $time, e.re, e.im, e.status,
                                 i_out.res_re, i_out.res_im, i_out.status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== verif/complex_arithmetic_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Sends directed and random operand transfers with random gaps and result
// stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_tb;

    localparam int W = 16;
    localparam int N_RANDOM = 1500;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   errors;
    int   pending;

    cau_in_if  #(.W(W)) in_ch();
    cau_out_if #(.W(W)) out_ch();

    complex_arithmetic_unit #(.DATA_WIDTH(W), .FRAC_BITS(8)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    complex_arithmetic_unit_checker #(.W(W), .FRAC(8)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .o_errors(errors), .o_pending(pending)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0;
        in_ch.func = cau_pkg::FUNC_ADD;
        in_ch.a_re = 0;
        in_ch.a_im = 0;
        in_ch.b_re = 0;
        in_ch.b_im = 0;
        out_ch.ready = 0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return W'($signed($urandom_range(0, 2047)) - 1024);
            4: return W'($signed($urandom_range(0, 127)) - 64);
            default: return W'($urandom);
        endcase
    endfunction

    task automatic send(input logic [1:0] func, input logic [W-1:0] ar, ai, br, bi);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.func <= func;
        in_ch.a_re <= ar;
        in_ch.a_im <= ai;
        in_ch.b_re <= br;
        in_ch.b_im <= bi;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Result stalls: random length, with occasional stall-free stretches.
    initial begin
        int g;
        @(posedge i_clk);
        while (i_rst_n !== 1) @(posedge i_clk);
        forever begin
            out_ch.ready <= 1;
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
            g = gap_len();
            if (g > 0) begin
                out_ch.ready <= 0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [1:0] f;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        for (int k = 0; k < 4; k++) begin
            f = 2'(k);
            send(f, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
            send(f, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
            send(f, 16'h0180, 16'hff80, 16'h0100, 16'h0080);
            send(f, 16'h0001, 16'hffff, 16'h0003, 16'h0000);
            send(f, 16'hffff, 16'hffff, 16'h0000, 16'h0001);
        end
        send(cau_pkg::FUNC_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
        send(cau_pkg::FUNC_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
        send(cau_pkg::FUNC_MUL, 16'h0080, 16'h0000, 16'h0001, 16'h0000);
        send(cau_pkg::FUNC_MUL, 16'hff80, 16'h0000, 16'h0001, 16'h0000);
        for (int n = 0; n < N_RANDOM; n++) begin
            f = 2'($urandom_range(0, 3));
            send(f, pick_value(), pick_value(), pick_value(), pick_value());
        end
        in_ch.valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== complex_arithmetic_unit.f =====
src/cau_pkg.sv
src/cau_if.sv
src/cau_front.sv
src/cau_div.sv
src/cau_post.sv
src/complex_arithmetic_unit.sv
src/cau_checker.sv
verif/complex_arithmetic_unit_checker.sv
verif/complex_arithmetic_unit_tb.sv
